### sv/lcrc8_pkg.sv
package lcrc8_pkg;

  localparam int LENGTH_BITS = 16;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam int         TAIL_LEN = 3;
  localparam int         OUT_LEN_W = 16;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] COUNT_TAIL = LENGTH_BITS'(TAIL_LEN);

  typedef logic [LENGTH_BITS-1:0] count_t;

  typedef struct packed {
    logic                 frame_ok;
    logic                 too_short;
    logic                 check_unparsable;
    logic [7:0]           computed_crc;
    logic [7:0]           received_crc;
    logic [OUT_LEN_W-1:0] line_length;
  } result_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### sv/lcrc8_line.sv
module lcrc8_line
  import lcrc8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  output result_t    result
);

  logic [7:0] crc_r, crc_nxt;
  logic [7:0] tail_r [TAIL_LEN];
  logic [7:0] tail_nxt [TAIL_LEN];
  count_t     count_r, count_nxt;
  logic [4:0] hi_dig, lo_dig;
  logic [7:0] rx_val;

  always_comb begin
    crc_nxt   = crc_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (step && data_byte != CH_CR) begin
      if (data_byte == CH_LF) begin
        crc_nxt   = 8'h00;
        count_nxt = '0;
        for (int i = 0; i < TAIL_LEN; i++) begin
          tail_nxt[i] = 8'h00;
        end
      end else begin
        if (count_r >= COUNT_TAIL) begin
          crc_nxt = crc_byte(crc_r, tail_r[0]);
        end
        for (int i = 0; i < TAIL_LEN - 1; i++) begin
          tail_nxt[i] = tail_r[i+1];
        end
        tail_nxt[TAIL_LEN-1] = data_byte;
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= 8'h00;
      count_r <= '0;
      for (int i = 0; i < TAIL_LEN; i++) begin
        tail_r[i] <= 8'h00;
      end
    end else begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      tail_r  <= tail_nxt;
    end
  end

  assign hi_dig = hex_val(tail_r[TAIL_LEN-2]);
  assign lo_dig = hex_val(tail_r[TAIL_LEN-1]);
  assign rx_val = lo_dig[4] ? {hi_dig[3:0], lo_dig[3:0]} : {4'h0, hi_dig[3:0]};

  always_comb begin
    result                  = '0;
    result.computed_crc     = crc_r;
    result.line_length      = OUT_LEN_W'(count_r);
    if (count_r < COUNT_TAIL) begin
      result.too_short = 1'b1;
    end else if (!hi_dig[4]) begin
      result.check_unparsable = 1'b1;
    end else begin
      result.received_crc = rx_val;
      result.frame_ok     = (rx_val == crc_r);
    end
  end

endmodule

### sv/line_crc8_frame_checker_core.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_stall   | in_data_byte
// result  | out_valid / out_stall | out_frame_ok, out_too_short, out_check_unparsable,
//         |                       | out_computed_crc, out_received_crc, out_line_length
// Bytes are registered on acceptance and processed one per cycle unless a newline is held.
// A newline's result is registered in the output register when the newline is processed.
// Reset is synchronous and clears the line state and both valid flags.
// A stalled result holds the next newline in the input register; earlier bytes keep flowing.
module line_crc8_frame_checker_core
  import lcrc8_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_frame_ok,
  output logic                 out_too_short,
  output logic                 out_check_unparsable,
  output logic [7:0]           out_computed_crc,
  output logic [7:0]           out_received_crc,
  output logic [OUT_LEN_W-1:0] out_line_length
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_go;
  logic       s1_lf;
  logic       out_free;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  result_t    line_res;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_lf    = (s1_byte_r == CH_LF);
  assign s1_go    = s1_valid_r && (!s1_lf || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  lcrc8_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_byte_r),
    .result    (line_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_go && s1_lf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
    end
    if (s1_go && s1_lf) begin
      out_r <= line_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_ok         = out_r.frame_ok;
  assign out_too_short        = out_r.too_short;
  assign out_check_unparsable = out_r.check_unparsable;
  assign out_computed_crc     = out_r.computed_crc;
  assign out_received_crc     = out_r.received_crc;
  assign out_line_length      = out_r.line_length;

endmodule

### sv/lcrc8_checker.sv
module lcrc8_checker
  import lcrc8_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_frame_ok,
  input logic                 out_too_short,
  input logic                 out_check_unparsable,
  input logic [7:0]           out_computed_crc,
  input logic [7:0]           out_received_crc,
  input logic [OUT_LEN_W-1:0] out_line_length
);

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

  a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_computed_crc)
      && $stable(out_line_length))
    else $error("stalled result transaction dropped or changed");

  a_short_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_short |-> !out_frame_ok && !out_check_unparsable
      && out_computed_crc == 8'h00 && out_received_crc == 8'h00
      && out_line_length < OUT_LEN_W'(TAIL_LEN))
    else $error("short line result inconsistent");

  a_unparsable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_check_unparsable |-> !out_frame_ok && out_received_crc == 8'h00)
    else $error("unparsable check result inconsistent");

  a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |-> out_received_crc == out_computed_crc)
    else $error("frame_ok set with mismatching check value");

endmodule

bind line_crc8_frame_checker_core lcrc8_checker u_lcrc8_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_frame_ok         (out_frame_ok),
  .out_too_short        (out_too_short),
  .out_check_unparsable (out_check_unparsable),
  .out_computed_crc     (out_computed_crc),
  .out_received_crc     (out_received_crc),
  .out_line_length      (out_line_length)
);

### dv/tb_line_crc8_frame_checker_core.sv
module tb_line_crc8_frame_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lcrc8_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 1250;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_frame_ok;
  logic                 out_too_short;
  logic                 out_check_unparsable;
  logic [7:0]           out_computed_crc;
  logic [7:0]           out_received_crc;
  logic [OUT_LEN_W-1:0] out_line_length;

  logic [7:0]  byte_feed_q[$];
  result_t     line_results_q[$];
  int unsigned text_bytes = 0;
  int unsigned bytes_taken = 0;
  int unsigned total_bytes = 0;
  int unsigned errors = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] cyc = '0;

  // Running state of the line being received.
  logic [7:0] line_crc = 8'h00;
  logic [7:0] tail_q[3] = '{8'h00, 8'h00, 8'h00};
  count_t     line_cnt = '0;

  line_crc8_frame_checker_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_ok         (out_frame_ok),
    .out_too_short        (out_too_short),
    .out_check_unparsable (out_check_unparsable),
    .out_computed_crc     (out_computed_crc),
    .out_received_crc     (out_received_crc),
    .out_line_length      (out_line_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    repeat (8) acc = acc[7] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    return acc;
  endfunction

  // Bit 4 set means the character is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] to_hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] line_crc_of(input byte_q_t body);
    logic [7:0] acc;
    acc = 8'h00;
    foreach (body[i]) begin
      if (body[i] != CH_CR) acc = crc8_next(acc, body[i]);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LF || b == CH_CR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = " ";
      1: b = "+";
      2: b = "-";
      3: b = "g";
      4: b = "G";
      default: begin
        b = rand_text_byte();
        while (hex_digit(b) != 5'd0) b = rand_text_byte();
      end
    endcase
    return b;
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_feed_q.insert(byte_feed_q.size(), b);
    if (b != CH_CR) text_bytes++;
  endtask

  task automatic push_frame(input byte_q_t body, input logic [7:0] sep,
                            input logic [7:0] hi_c, input logic [7:0] lo_c, input bit with_cr);
    foreach (body[i]) push_byte(body[i]);
    push_byte(sep);
    push_byte(hi_c);
    push_byte(lo_c);
    if (with_cr) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic track_line_byte(input logic [7:0] b);
    result_t    r;
    logic [4:0] hi;
    logic [4:0] lo;
    if (b == CH_CR) return;
    if (b != CH_LF) begin
      if (line_cnt >= COUNT_TAIL) line_crc = crc8_next(line_crc, tail_q[0]);
      tail_q[0] = tail_q[1];
      tail_q[1] = tail_q[2];
      tail_q[2] = b;
      if (line_cnt != COUNT_MAX) line_cnt++;
      return;
    end
    r = '0;
    r.computed_crc = line_crc;
    r.line_length  = OUT_LEN_W'(line_cnt);
    if (line_cnt < COUNT_TAIL) begin
      r.too_short = 1'b1;
    end else begin
      hi = hex_digit(tail_q[1]);
      lo = hex_digit(tail_q[2]);
      if (!hi[4]) begin
        r.check_unparsable = 1'b1;
      end else begin
        r.received_crc = lo[4] ? {hi[3:0], lo[3:0]} : {4'h0, hi[3:0]};
        r.frame_ok     = (r.received_crc == line_crc);
      end
    end
    line_results_q.insert(line_results_q.size(), r);
    line_crc = 8'h00;
    tail_q   = '{8'h00, 8'h00, 8'h00};
    line_cnt = '0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_line_byte(in_data_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0 || byte_feed_q.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          in_data_byte <= byte_feed_q.pop_front();
          send_gap = pick_gap(cyc[9:8] == 2'b11);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_results_q.size() == 0) begin
          errors++;
          $display("%0t: result transaction with no result expected: expected none, actual %p",
                   $time, {out_frame_ok, out_too_short, out_check_unparsable, out_computed_crc,
                           out_received_crc, out_line_length});
        end else begin
          want = line_results_q.pop_front();
          check_field("frame_ok", 16'(want.frame_ok), 16'(out_frame_ok));
          check_field("too_short", 16'(want.too_short), 16'(out_too_short));
          check_field("check_unparsable", 16'(want.check_unparsable),
                      16'(out_check_unparsable));
          check_field("computed_crc", 16'(want.computed_crc), 16'(out_computed_crc));
          check_field("received_crc", 16'(want.received_crc), 16'(out_received_crc));
          check_field("line_length", 16'(want.line_length), 16'(out_line_length));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(cyc[9:8] == 2'b01);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t     body;
    int unsigned n;
    int unsigned pick;
    int unsigned start_bytes;
    logic [7:0]  crc;
    logic [7:0]  hi_c;
    logic [7:0]  lo_c;

    push_byte(CH_LF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_LF);
    body = {};
    push_frame(body, 8'hFF, " ", "5", 1'b0);
    body = {8'h00};
    push_frame(body, "+", "-", "a", 1'b0);
    body = {8'h41};
    crc = line_crc_of(body);
    push_frame(body, ",", to_hex_char(crc[7:4], 1'b1), to_hex_char(crc[3:0], 1'b1), 1'b1);
    body = {};
    push_frame(body, "x", "0", "z", 1'b0);

    start_bytes = text_bytes;
    while (text_bytes - start_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick >= 88) begin
        n = $urandom_range(0, 6);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        push_byte(CH_LF);
      end else begin
        body = {};
        n = (pick < 3) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) body.insert(body.size(), CH_CR);
          body.insert(body.size(), rand_text_byte());
        end
        crc = line_crc_of(body);
        if (pick < 60) begin
          hi_c = to_hex_char(crc[7:4], 1'($urandom_range(0, 1)));
          lo_c = to_hex_char(crc[3:0], 1'($urandom_range(0, 1)));
        end else if (pick < 72) begin
          hi_c = to_hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          lo_c = to_hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else if (pick < 80) begin
          hi_c = to_hex_char(crc[3:0], 1'($urandom_range(0, 1)));
          lo_c = rand_non_hex();
        end else begin
          hi_c = rand_non_hex();
          lo_c = rand_text_byte();
        end
        push_frame(body, rand_text_byte(), hi_c, lo_c, 1'($urandom_range(0, 2) == 0));
      end
    end
    total_bytes = byte_feed_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != total_bytes) @(posedge clk);
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### line_crc8_frame_checker_core.f
sv/lcrc8_pkg.sv
sv/lcrc8_line.sv
sv/line_crc8_frame_checker_core.sv
sv/lcrc8_checker.sv
dv/tb_line_crc8_frame_checker_core.sv
